### sv/crw_pkg.sv
// ----------------------------------------------------------------------------
// crw_pkg: shared types and constants of the reachability walker
// Request and response payloads, request kinds, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package crw_pkg;

   localparam int MaxNodesDefault = 64;
   localparam int MaxSuccDefault  = 2;
   localparam int MaxPredDefault  = 4;
   localparam int NodeW           = 7;
   localparam int SlotW           = 2;
   localparam int ProcW           = 6;

   typedef enum logic [2:0] {
      KIND_LOAD_SUCC = 3'd0,
      KIND_LOAD_PRED = 3'd1,
      KIND_SET_PROC  = 3'd2,
      KIND_REACH     = 3'd3,
      KIND_FWD_LIST  = 3'd4,
      KIND_BWD_LIST  = 3'd5,
      KIND_RSVD6     = 3'd6,
      KIND_RSVD7     = 3'd7
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [NodeW-1:0]  node;
      logic [SlotW-1:0]  slot;
      logic [NodeW-1:0]  neighbor;
      logic [ProcW-1:0]  proc_id;
      logic [NodeW-1:0]  target;
   } req_type;

   typedef struct packed {
      logic              reachable;
      logic [NodeW-1:0]  listed_node;
      logic              last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROC_RD,
      ST_PROC_CHK,
      ST_START,
      ST_SLOT_RD,
      ST_SLOT_CHK,
      ST_POP_RD,
      ST_POP_WAIT,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_SINGLE_OUT,
      ST_CLEAR
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch request
      logic clear_step;  // zero one slot of a table row during clear pass
      logic write_tbl;   // perform load/set write
      logic proc_rd;     // read procedure of node
      logic proc_rd2;    // read procedure of target
      logic start_walk;  // cur <= node, clear marks and pointers
      logic slot_rd;     // read slot of cur
      logic slot_chk;    // test slot value, enqueue
      logic pop_rd;      // read queue head
      logic pop_take;    // cur <= queue head
      logic emit_rd;     // read queue entry for output
      logic emit_adv;    // advance output pointer
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_load;
      logic is_reach;
      logic is_list;
      logic procs_ok;    // procedure check passed
      logic slot_last;   // current slot is the last one
      logic queue_more;  // head < tail
      logic queue_empty; // tail == 0
      logic emit_last;   // output pointer at last entry
      logic clear_done;
   } sts_type;

endpackage

### sv/crw_ram.sv
// ----------------------------------------------------------------------------
// crw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module crw_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/crw_ctrl.sv
// ----------------------------------------------------------------------------
// crw_ctrl: walker controller
// Sequences clear pass, table loads, procedure check, the breadth-first walk
// and the result stream.
// ----------------------------------------------------------------------------
module crw_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output crw_pkg::cmd_type cmd,
   output logic            rsp_single,
   input  crw_pkg::sts_type sts
);
   import crw_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      rsp_single = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_PROC_RD;
            end
         end
         ST_PROC_RD: begin
            cmd.proc_rd = 1'b1;
            if (sts.is_load) begin
               cmd.write_tbl = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.is_reach || sts.is_list) begin
               state_in = ST_PROC_CHK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PROC_CHK: begin
            cmd.proc_rd2 = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            if (sts.procs_ok) begin
               cmd.start_walk = 1'b1;
               state_in = ST_SLOT_RD;
            end else begin
               state_in = ST_SINGLE_OUT;
            end
         end
         ST_SLOT_RD: begin
            cmd.slot_rd = 1'b1;
            state_in = ST_SLOT_CHK;
         end
         ST_SLOT_CHK: begin
            cmd.slot_chk = 1'b1;
            if (!sts.slot_last) begin
               state_in = ST_SLOT_RD;
            end else if (sts.queue_more) begin
               state_in = ST_POP_RD;
            end else if (sts.is_reach || sts.queue_empty) begin
               state_in = ST_SINGLE_OUT;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_POP_RD: begin
            cmd.pop_rd = 1'b1;
            state_in = ST_POP_WAIT;
         end
         ST_POP_WAIT: begin
            cmd.pop_take = 1'b1;
            state_in = ST_SLOT_RD;
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_adv = 1'b1;
               state_in = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_SINGLE_OUT: begin
            rsp_valid  = 1'b1;
            rsp_single = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/crw_dpath.sv
// ----------------------------------------------------------------------------
// crw_dpath: walker datapath
// Graph tables in RAM, visited marks, walk queue and its pointers.
// ----------------------------------------------------------------------------
module crw_dpath #(
   parameter int MaxNodes = crw_pkg::MaxNodesDefault,
   parameter int MaxSucc  = crw_pkg::MaxSuccDefault,
   parameter int MaxPred  = crw_pkg::MaxPredDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  crw_pkg::req_type req_data,
   input  crw_pkg::cmd_type cmd,
   input  logic             rsp_single,
   output crw_pkg::sts_type sts,
   output crw_pkg::rsp_type rsp_data
);
   import crw_pkg::*;

   localparam int NIdxW    = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
   localparam int SuccD    = MaxNodes * MaxSucc;
   localparam int PredD    = MaxNodes * MaxPred;
   localparam int SuccAW   = $clog2(SuccD);
   localparam int PredAW   = $clog2(PredD);
   localparam int CntW     = $clog2(MaxNodes + 1);
   localparam int ClrSlots = (MaxPred > MaxSucc) ? MaxPred : MaxSucc;
   localparam int ClrW     = (ClrSlots > 1) ? $clog2(ClrSlots) : 1;

   req_type            req_ff;
   logic [NIdxW-1:0]   clr_ff;
   logic [ClrW-1:0]    clr_slot_ff;
   logic               clr_row_end;
   logic               clr_done_ff;
   logic [NodeW-1:0]   cur_ff;
   logic [SlotW-1:0]   slot_ff;
   logic [MaxNodes-1:0] marks_ff;
   logic [CntW-1:0]    head_ff, tail_ff, emit_ff;
   logic [ProcW-1:0]   proc1_ff;
   logic               procs_ok;
   logic               procs_ok_hold_ff;
   logic [NodeW-1:0]   emit_node;
   logic               last_ff;

   // node checks
   function automatic logic node_ok(input logic [NodeW-1:0] n);
      return (n != '0) && ({25'd0, n} <= MaxNodes);
   endfunction

   logic [NIdxW-1:0] node_idx, target_idx, cur_idx;
   logic [NodeW-1:0] nb_clean;
   logic             is_fwd;
   assign node_idx   = NIdxW'(req_ff.node - 7'd1);
   assign target_idx = NIdxW'(req_ff.target - 7'd1);
   assign cur_idx    = NIdxW'(cur_ff - 7'd1);
   assign nb_clean   = node_ok(req_ff.neighbor) ? req_ff.neighbor : '0;
   assign is_fwd     = (req_ff.kind != KIND_BWD_LIST);

   // successor RAM
   logic              s_we;
   logic [SuccAW-1:0] s_wa, s_ra;
   logic [NodeW-1:0]  s_wd, s_rd;
   always_comb begin
      s_we = 1'b0;
      s_wa = SuccAW'(node_idx * MaxSucc + 32'(req_ff.slot));
      s_wd = nb_clean;
      if (!clr_done_ff) begin
         s_we = (32'(clr_slot_ff) < MaxSucc);
         s_wa = SuccAW'(clr_ff * MaxSucc + 32'(clr_slot_ff));
         s_wd = '0;
      end else if (cmd.write_tbl && req_ff.kind == KIND_LOAD_SUCC
                   && node_ok(req_ff.node) && 32'(req_ff.slot) < MaxSucc) begin
         s_we = 1'b1;
      end
      s_ra = SuccAW'(cur_idx * MaxSucc + 32'(slot_ff));
   end

   crw_ram #(.Width(NodeW), .Depth(SuccD)) u_succ (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd)
   );

   // predecessor RAM
   logic              p_we;
   logic [PredAW-1:0] p_wa, p_ra;
   logic [NodeW-1:0]  p_wd, p_rd;
   always_comb begin
      p_we = 1'b0;
      p_wa = PredAW'(node_idx * MaxPred + 32'(req_ff.slot));
      p_wd = nb_clean;
      if (!clr_done_ff) begin
         p_we = (32'(clr_slot_ff) < MaxPred);
         p_wa = PredAW'(clr_ff * MaxPred + 32'(clr_slot_ff));
         p_wd = '0;
      end else if (cmd.write_tbl && req_ff.kind == KIND_LOAD_PRED
                   && node_ok(req_ff.node) && 32'(req_ff.slot) < MaxPred) begin
         p_we = 1'b1;
      end
      p_ra = PredAW'(cur_idx * MaxPred + 32'(slot_ff));
   end

   crw_ram #(.Width(NodeW), .Depth(PredD)) u_pred (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd)
   );

   // procedure RAM
   logic              r_we;
   logic [NIdxW-1:0]  r_wa, r_ra;
   logic [ProcW-1:0]  r_wd, r_rd;
   always_comb begin
      r_we = 1'b0;
      r_wa = node_idx;
      r_wd = req_ff.proc_id;
      if (!clr_done_ff) begin
         r_we = 1'b1;
         r_wa = clr_ff;
         r_wd = '0;
      end else if (cmd.write_tbl && req_ff.kind == KIND_SET_PROC
                   && node_ok(req_ff.node)) begin
         r_we = 1'b1;
      end
      r_ra = cmd.proc_rd2 ? target_idx : node_idx;
   end

   crw_ram #(.Width(ProcW), .Depth(MaxNodes)) u_proc (
      .clock(clock), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
      .rd_addr(r_ra), .rd_data(r_rd)
   );

   // walk queue; hold the output address outside pops so a stalled
   // response keeps its payload
   logic             q_we;
   logic [NIdxW-1:0] q_wa, q_ra;
   logic [NodeW-1:0] q_rd, nb_rd;
   logic             nb_new;
   assign nb_rd  = is_fwd ? s_rd : p_rd;
   assign nb_new = node_ok(nb_rd) && !marks_ff[NIdxW'(nb_rd - 7'd1)]
                   && ({25'd0, tail_ff} < MaxNodes);
   assign q_we   = cmd.slot_chk && nb_new;
   assign q_wa   = NIdxW'(tail_ff);
   assign q_ra   = cmd.pop_rd ? NIdxW'(head_ff) : NIdxW'(emit_ff);

   crw_ram #(.Width(NodeW), .Depth(MaxNodes)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(nb_rd),
      .rd_addr(q_ra), .rd_data(q_rd)
   );

   // clear pass over all rows, one slot per cycle
   assign clr_row_end = (32'(clr_slot_ff) == ClrSlots - 1) || (ClrSlots == 1);

   // clear, request, walk and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_slot_ff <= '0;
         clr_done_ff <= 1'b0;
      end else if (!clr_done_ff && cmd.clear_step) begin
         if (clr_row_end) begin
            clr_slot_ff <= '0;
            if (32'(clr_ff) == MaxNodes - 1) begin
               clr_done_ff <= 1'b1;
            end else begin
               clr_ff <= clr_ff + 1'b1;
            end
         end else begin
            clr_slot_ff <= clr_slot_ff + 1'b1;
         end
      end

      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.proc_rd2) begin
         proc1_ff <= r_rd;
      end
      if (cmd.start_walk) begin
         cur_ff   <= req_ff.node;
         slot_ff  <= '0;
         marks_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         emit_ff  <= '0;
      end
      if (cmd.slot_chk) begin
         slot_ff <= slot_ff + 1'b1;
         if (nb_new) begin
            marks_ff[NIdxW'(nb_rd - 7'd1)] <= 1'b1;
            tail_ff <= tail_ff + 1'b1;
         end
      end
      if (cmd.pop_rd) begin
         head_ff <= head_ff + 1'b1;
      end
      if (cmd.pop_take) begin
         cur_ff  <= q_rd;
         slot_ff <= '0;
      end
      if (cmd.emit_rd) begin
         last_ff <= (emit_ff == tail_ff - 1'b1);
      end
      if (cmd.emit_adv) begin
         emit_ff <= emit_ff + 1'b1;
      end
   end

   // procedure check result, taken in the cycle after the target read
   always_comb begin
      procs_ok = 1'b0;
      if (req_ff.kind == KIND_REACH) begin
         procs_ok = node_ok(req_ff.node) && node_ok(req_ff.target)
                    && proc1_ff != '0 && r_rd == proc1_ff;
      end else begin
         procs_ok = node_ok(req_ff.node) && proc1_ff != '0;
      end
   end
   assign emit_node = q_rd;

   // status
   logic [SlotW-1:0] slot_max;
   assign slot_max = is_fwd ? SlotW'(MaxSucc - 1) : SlotW'(MaxPred - 1);
   always_comb begin
      sts             = '0;
      sts.is_load     = (req_ff.kind == KIND_LOAD_SUCC) || (req_ff.kind == KIND_LOAD_PRED)
                        || (req_ff.kind == KIND_SET_PROC);
      sts.is_reach    = (req_ff.kind == KIND_REACH);
      sts.is_list     = (req_ff.kind == KIND_FWD_LIST) || (req_ff.kind == KIND_BWD_LIST);
      sts.procs_ok    = procs_ok;
      sts.slot_last   = (slot_ff == slot_max);
      sts.queue_more  = (head_ff != tail_ff) || (cmd.slot_chk && nb_new);
      sts.queue_empty = (tail_ff == '0) && !(cmd.slot_chk && nb_new);
      sts.emit_last   = last_ff;
      sts.clear_done  = clr_done_ff;
   end

   // response payload
   always_comb begin
      rsp_data = '0;
      if (rsp_single) begin
         rsp_data.last = 1'b1;
         if (req_ff.kind == KIND_REACH && procs_ok_hold_ff) begin
            rsp_data.reachable = marks_ff[target_idx];
         end
      end else begin
         rsp_data.listed_node = emit_node;
         rsp_data.last        = last_ff;
      end
   end

   // hold the check result across the walk
   always_ff @(posedge clock) begin
      if (cmd.proc_rd2) begin
         procs_ok_hold_ff <= 1'b0;
      end else if (cmd.start_walk) begin
         procs_ok_hold_ff <= 1'b1;
      end
   end

endmodule

### sv/cfg_reachability_walker.sv
// ----------------------------------------------------------------------------
// cfg_reachability_walker: control-flow graph reachability engine
// Loads a graph through requests and answers reach and list queries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready with a req_type payload. Loads
//   (successor, predecessor, procedure) give no response. A reach query
//   gives one response; a list query gives one response per reached node
//   in breadth-first order, last set on the final one, or a single
//   response with node 0 if nothing is reached. A walk reads each slot of
//   each reached node from the graph RAM and each dequeued node from the
//   queue RAM; each listed node is read from the queue RAM before it is
//   output. The single read port of the graph RAM sets the walk's pace.
//   One request is in work at a time. After reset a clearing pass zeros
//   the tables; req_ready stays low until it ends. When the receiver holds
//   rsp_ready low, the response holds and no new request is taken.
// ----------------------------------------------------------------------------
module cfg_reachability_walker #(
   parameter int MaxNodes = crw_pkg::MaxNodesDefault,
   parameter int MaxSucc  = crw_pkg::MaxSuccDefault,
   parameter int MaxPred  = crw_pkg::MaxPredDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  crw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output crw_pkg::rsp_type rsp_data
);
   import crw_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    rsp_single;

   crw_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .rsp_single(rsp_single), .sts(sts)
   );

   crw_dpath #(.MaxNodes(MaxNodes), .MaxSucc(MaxSucc), .MaxPred(MaxPred)) u_dpath (
      .clock(clock), .reset(reset), .req_data(req_data),
      .cmd(cmd), .rsp_single(rsp_single), .sts(sts), .rsp_data(rsp_data)
   );

endmodule

### tb/crw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crw_checker: response predictor and scoreboard for the reachability walker
// Watches accepted requests, keeps a shadow copy of the graph, computes the
// responses each query should give and compares them with the ones seen.
// ----------------------------------------------------------------------------
module crw_checker #(
   parameter int MaxNodes = crw_pkg::MaxNodesDefault,
   parameter int MaxSucc  = crw_pkg::MaxSuccDefault,
   parameter int MaxPred  = crw_pkg::MaxPredDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  crw_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  crw_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_rsp
);
   import crw_pkg::*;

   logic [NodeW-1:0] succ_shadow [MaxNodes*MaxSucc];
   logic [NodeW-1:0] pred_shadow [MaxNodes*MaxPred];
   logic [ProcW-1:0] proc_shadow [MaxNodes];
   logic [NodeW-1:0] bfs_order [$];
   logic [63:0]      seen_set;
   rsp_type          expected_rsp [$];

   assign pending_rsp = expected_rsp.size();

   function automatic bit node_valid(input int n);
      return n >= 1 && n <= MaxNodes;
   endfunction

   function automatic logic [ProcW-1:0] proc_lookup(input int n);
      return node_valid(n) ? proc_shadow[n-1] : '0;
   endfunction

   // breadth-first walk; fills bfs_order and seen_set, marks on enqueue
   task automatic run_bfs(input int start, input bit backward);
      int width, cur, head, nb;
      width = backward ? MaxPred : MaxSucc;
      seen_set = '0;
      bfs_order.delete();
      head = 0;
      cur = start;
      forever begin
         for (int s = 0; s < width; s++) begin
            nb = backward ? pred_shadow[(cur-1)*width+s] : succ_shadow[(cur-1)*width+s];
            if (!node_valid(nb) || seen_set[nb-1] || bfs_order.size() >= MaxNodes) continue;
            seen_set[nb-1] = 1'b1;
            bfs_order = {bfs_order, nb[NodeW-1:0]};
         end
         if (head >= bfs_order.size()) break;
         cur = bfs_order[head];
         head++;
      end
   endtask

   // update shadow state and queue expected responses for one request
   task automatic predict_request(input req_type rq);
      int node, nb, tgt;
      logic [ProcW-1:0] p1, p2;
      rsp_type r;
      node = rq.node;
      tgt = rq.target;
      nb = node_valid(rq.neighbor) ? rq.neighbor : 0;
      case (rq.kind)
         KIND_LOAD_SUCC: if (node_valid(node) && rq.slot < MaxSucc)
            succ_shadow[(node-1)*MaxSucc+rq.slot] = nb[NodeW-1:0];
         KIND_LOAD_PRED: if (node_valid(node) && rq.slot < MaxPred)
            pred_shadow[(node-1)*MaxPred+rq.slot] = nb[NodeW-1:0];
         KIND_SET_PROC: if (node_valid(node))
            proc_shadow[node-1] = rq.proc_id;
         KIND_REACH: begin
            p1 = proc_lookup(node);
            p2 = proc_lookup(tgt);
            r = '0;
            r.last = 1'b1;
            if (p1 != 0 && p2 != 0 && p1 == p2) begin
               run_bfs(node, 1'b0);
               r.reachable = seen_set[tgt-1];
            end
            expected_rsp = {expected_rsp, r};
         end
         KIND_FWD_LIST, KIND_BWD_LIST: begin
            bfs_order.delete();
            if (proc_lookup(node) != 0) run_bfs(node, rq.kind == KIND_BWD_LIST);
            if (bfs_order.size() == 0) begin
               r = '0;
               r.last = 1'b1;
               expected_rsp = {expected_rsp, r};
            end else begin
               foreach (bfs_order[i]) begin
                  r = '0;
                  r.listed_node = bfs_order[i];
                  r.last = (i == bfs_order.size() - 1);
                  expected_rsp = {expected_rsp, r};
               end
            end
         end
         default: ;
      endcase
   endtask

   // observe both channels at the clock edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (succ_shadow[i]) succ_shadow[i] = '0;
         foreach (pred_shadow[i]) pred_shadow[i] = '0;
         foreach (proc_shadow[i]) proc_shadow[i] = '0;
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected response %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (want.reachable !== rsp_data.reachable ||
                   want.listed_node !== rsp_data.listed_node ||
                   want.last !== rsp_data.last) begin
                  if (fail_count < 10)
                     $display("ERROR: response mismatch: expected %p, got %p",
                              want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_request(req_data);
      end
   end

   initial fail_count = 0;

endmodule

### tb/tb_cfg_reachability_walker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cfg_reachability_walker: testbench top for the reachability walker
// Loads small graphs, issues reach and list queries with random gaps and
// response stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_cfg_reachability_walker;
   import crw_pkg::*;

   localparam int CycleLimit = 3000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_rsp;
   int      cycle_count = 0;
   bit      long_hold = 1'b0;

   always #2 clock = ~clock;

   cfg_reachability_walker dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   crw_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_rsp(pending_rsp)
   );

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
   endfunction

   // abort on runaway
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         n = gap_len();
         if ($urandom_range(0, 3) == 0) n = 0;
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // present one request and wait for acceptance; valid stays up for the caller
   task automatic send_req(input req_type rq);
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop valid only when an idle gap follows
   task automatic send_gap(input req_type rq, input bit no_gap);
      int n;
      send_req(rq);
      n = no_gap ? 0 : gap_len();
      if ($urandom_range(0, 4) == 0) n = 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic req_type mk(input kind_type k, input int nd, input int sl,
                                  input int nb, input int pr, input int tg);
      req_type rq;
      rq.kind = k;
      rq.node = nd[NodeW-1:0];
      rq.slot = sl[SlotW-1:0];
      rq.neighbor = nb[NodeW-1:0];
      rq.proc_id = pr[ProcW-1:0];
      rq.target = tg[NodeW-1:0];
      return rq;
   endfunction

   function automatic int rand_node();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(65, 127);
      if (r < 4) return $urandom_range(1, 64);
      return $urandom_range(1, 12);
   endfunction

   function automatic req_type rand_req(input bit mostly_query);
      req_type rq;
      int k;
      rq = $urandom();
      k = $urandom_range(0, 19);
      if (k < (mostly_query ? 6 : 10)) rq.kind = kind_type'($urandom_range(0, 2));
      else if (k < 19) rq.kind = kind_type'($urandom_range(3, 5));
      else rq.kind = kind_type'($urandom_range(6, 7));
      rq.node = NodeW'(rand_node());
      rq.target = NodeW'(rand_node());
      rq.neighbor = NodeW'(rand_node());
      rq.proc_id = ($urandom_range(0, 3) == 0) ? ProcW'($urandom())
                                               : ProcW'($urandom_range(0, 3));
      return rq;
   endfunction

   // stimulus
   initial begin
      int accepted;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small graph 1->2->3->1, 3->4, node 64 and extremes
      send_gap(mk(KIND_SET_PROC, 1, 0, 0, 5, 0), 0);
      send_gap(mk(KIND_SET_PROC, 2, 0, 0, 5, 0), 0);
      send_gap(mk(KIND_SET_PROC, 4, 0, 0, 63, 0), 0);
      send_gap(mk(KIND_SET_PROC, 64, 0, 0, 5, 0), 0);
      send_gap(mk(KIND_LOAD_SUCC, 1, 0, 2, 0, 0), 0);
      send_gap(mk(KIND_LOAD_SUCC, 2, 1, 3, 0, 0), 0);
      send_gap(mk(KIND_LOAD_SUCC, 3, 0, 1, 0, 0), 0);
      send_gap(mk(KIND_LOAD_SUCC, 3, 1, 4, 0, 0), 0);
      send_gap(mk(KIND_LOAD_SUCC, 3, 3, 64, 0, 0), 0);   // slot out of range
      send_gap(mk(KIND_LOAD_SUCC, 4, 0, 127, 0, 0), 0);  // neighbor stored empty
      send_gap(mk(KIND_LOAD_PRED, 1, 3, 64, 0, 0), 0);
      send_gap(mk(KIND_LOAD_PRED, 64, 0, 1, 0, 0), 0);
      send_gap(mk(KIND_LOAD_PRED, 0, 0, 1, 0, 0), 0);    // invalid node
      send_gap(mk(KIND_SET_PROC, 127, 0, 0, 5, 0), 0);
      send_gap(mk(KIND_REACH, 1, 0, 0, 0, 1), 0);        // start through cycle
      send_gap(mk(KIND_REACH, 1, 0, 0, 0, 64), 0);
      send_gap(mk(KIND_REACH, 1, 0, 0, 0, 4), 0);        // procedure mismatch
      send_gap(mk(KIND_REACH, 0, 0, 0, 0, 127), 0);
      send_gap(mk(KIND_FWD_LIST, 1, 0, 0, 0, 0), 0);
      send_gap(mk(KIND_BWD_LIST, 1, 0, 0, 0, 0), 0);
      send_gap(mk(KIND_FWD_LIST, 3, 0, 0, 0, 0), 0);     // no procedure
      send_gap(mk(KIND_FWD_LIST, 2, 0, 0, 0, 0), 0);
      send_gap(mk(KIND_RSVD6, 1, 0, 0, 0, 0), 0);
      send_gap(mk(KIND_RSVD7, 127, 3, 127, 63, 127), 0);

      // sender pauses until every response is in
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp != 0) @(posedge clock);

      // receiver holds off while the sender keeps offering queries
      long_hold = 1'b1;
      for (int i = 0; i < 6; i++) send_gap(mk(KIND_FWD_LIST, 1, 0, 0, 0, 0), 1);

      // random part
      accepted = 0;
      while (accepted < 100) begin
         send_gap(rand_req(accepted > 40), 0);
         accepted++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (fail_count == 0 && pending_rsp == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
